// ----- design/tscp_pkg.sv -----
// Shared types and constants of the triangle shade, cull and projection block.
// Used by tscp_vertex and triangle_shade_cull_project_top; depends on nothing.
package tscp_pkg;

  // Vertex coordinates are Q4.12, trig values Q1.14
  localparam int unsigned VW = 16;
  localparam int unsigned TW = 16;

  // Trig register reset value (1.0 in Q1.14)
  localparam logic signed [TW-1:0] TRIG_ONE = 16'sd16384;

  // Projection: w = 5.0 + z in Q.12, screen offset numerator 2 * 300 * 16
  localparam int W_BIAS   = 20480;
  localparam int PROJ_K   = 9600;
  localparam int CENTER_X = 6400;
  localparam int CENTER_Y = 4800;

  // Rounding bias for the Q.26 to Q.12 step
  localparam int RND_BIAS = 8192;

  // Shading: per channel scale squared and base, index 0 red, 1 green, 2 blue
  localparam logic [2:0][15:0] CHAN_SQ   = {16'd3025, 16'd22500, 16'd40000};
  localparam logic [2:0][7:0]  CHAN_BASE = {8'd200, 8'd100, 8'd50};
  // Squared norm of the light direction (5,7,10)
  localparam int LIGHT_N2 = 174;

  // Configuration register indexes
  typedef enum logic [2:0] {
    CfgCosX = 3'd0,
    CfgSinX = 3'd1,
    CfgCosY = 3'd2,
    CfgSinY = 3'd3,
    CfgCosZ = 3'd4,
    CfgSinZ = 3'd5
  } cfg_idx_e;

  typedef struct packed {
    logic signed [TW-1:0] cos_x;
    logic signed [TW-1:0] sin_x;
    logic signed [TW-1:0] cos_y;
    logic signed [TW-1:0] sin_y;
    logic signed [TW-1:0] cos_z;
    logic signed [TW-1:0] sin_z;
  } trig_t;

endpackage

// ----- design/tscp_vertex.sv -----
// One vertex: rotation about X, Y and Z, then perspective projection through
// a pipelined restoring divider. Depends on tscp_pkg.
module tscp_vertex #(
  parameter int unsigned COORD_WIDTH = 16
) (
  input  logic                           clk_i,
  input  logic                           en_i,
  input  tscp_pkg::trig_t                trig_i,
  input  logic signed [tscp_pkg::VW-1:0] x_i,
  input  logic signed [tscp_pkg::VW-1:0] y_i,
  input  logic signed [tscp_pkg::VW-1:0] z_i,
  output logic signed [COORD_WIDTH-1:0]  sx_o,
  output logic signed [COORD_WIDTH-1:0]  sy_o,
  output logic                           ok_o
);
  import tscp_pkg::*;

  // Quotient bits kept before saturation, remainder and divisor widths
  localparam int unsigned QW   = COORD_WIDTH + 2;
  localparam int unsigned NW   = 43;
  localparam int unsigned DENW = 26;
  localparam int unsigned SUMW = QW + 2;

  localparam logic signed [SUMW-1:0] SatHi =
    SUMW'((64'd1 << (COORD_WIDTH - 1)) - 64'd1);
  localparam logic signed [SUMW-1:0] SatLo = -SatHi - SUMW'(1);
  localparam logic signed [SUMW-1:0] CtrX  = SUMW'(CENTER_X);
  localparam logic signed [SUMW-1:0] CtrY  = SUMW'(CENTER_Y);

  typedef struct packed {
    logic [NW-1:0]   rem_x;
    logic [NW-1:0]   rem_y;
    logic [QW-1:0]   q_x;
    logic [QW-1:0]   q_y;
    logic            neg_x;
    logic            neg_y;
    logic            ovf_x;
    logic            ovf_y;
    logic            ok;
    logic [DENW-1:0] den;
  } div_t;

  // Rotate about X
  logic signed [31:0] p1a, p1b, p1c, p1d;
  logic signed [33:0] t1y, t1z;
  logic signed [15:0] s1_x_q;
  logic signed [19:0] s1_y_q, s1_z_q;

  assign p1a = y_i * trig_i.cos_x;
  assign p1b = z_i * trig_i.sin_x;
  assign p1c = y_i * trig_i.sin_x;
  assign p1d = z_i * trig_i.cos_x;
  assign t1y = 34'(p1a) - 34'(p1b) + 34'(RND_BIAS);
  assign t1z = 34'(p1c) + 34'(p1d) + 34'(RND_BIAS);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      s1_x_q <= x_i;
      s1_y_q <= t1y[33:14];
      s1_z_q <= t1z[33:14];
    end
  end

  // Rotate about Y
  logic signed [31:0] p2a, p2d;
  logic signed [35:0] p2b, p2c;
  logic signed [37:0] t2x, t2z;
  logic signed [23:0] s2_x_q, s2_z_q;
  logic signed [19:0] s2_y_q;

  assign p2a = s1_x_q * trig_i.cos_y;
  assign p2b = s1_z_q * trig_i.sin_y;
  assign p2c = s1_z_q * trig_i.cos_y;
  assign p2d = s1_x_q * trig_i.sin_y;
  assign t2x = 38'(p2a) + 38'(p2b) + 38'(RND_BIAS);
  assign t2z = 38'(p2c) - 38'(p2d) + 38'(RND_BIAS);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      s2_x_q <= t2x[37:14];
      s2_y_q <= s1_y_q;
      s2_z_q <= t2z[37:14];
    end
  end

  // Rotate about Z
  logic signed [39:0] p3a, p3c;
  logic signed [35:0] p3b, p3d;
  logic signed [41:0] t3x, t3y;
  logic signed [27:0] s3_x_q, s3_y_q;
  logic signed [23:0] s3_z_q;

  assign p3a = s2_x_q * trig_i.cos_z;
  assign p3b = s2_y_q * trig_i.sin_z;
  assign p3c = s2_x_q * trig_i.sin_z;
  assign p3d = s2_y_q * trig_i.cos_z;
  assign t3x = 42'(p3a) - 42'(p3b) + 42'(RND_BIAS);
  assign t3y = 42'(p3c) + 42'(p3d) + 42'(RND_BIAS);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      s3_x_q <= t3x[41:14];
      s3_y_q <= t3y[41:14];
      s3_z_q <= s2_z_q;
    end
  end

  // Depth, numerators and magnitudes for floor division by 2w
  logic signed [24:0]   w;
  logic                 w_ok;
  logic signed [NW-1:0] num_x, num_y;
  logic [DENW-1:0]      den;
  div_t                 prep_d, prep_q;

  assign w     = 25'(s3_z_q) + 25'(W_BIAS);
  assign w_ok  = !w[24] && (w != '0);
  assign num_x = 43'(s3_x_q) * 43'(PROJ_K) + 43'(w);
  assign num_y = 43'(s3_y_q) * 43'(PROJ_K) + 43'(w);
  assign den   = w_ok ? {w, 1'b0} : DENW'(1);

  always_comb begin
    prep_d       = '0;
    prep_d.ok    = w_ok;
    prep_d.den   = den;
    prep_d.neg_x = num_x[NW-1];
    prep_d.neg_y = num_y[NW-1];
    // Negative numerators divide with ceiling so the final negation floors
    prep_d.rem_x = num_x[NW-1] ? (NW'(-num_x) + NW'(den) - NW'(1)) : NW'(num_x);
    prep_d.rem_y = num_y[NW-1] ? (NW'(-num_y) + NW'(den) - NW'(1)) : NW'(num_y);
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      prep_q <= prep_d;
    end
  end

  // Restoring divider, one quotient bit per stage, most significant first
  div_t dv_q [QW];

  for (genvar k = 0; k < QW; k++) begin : g_div
    localparam int unsigned Sh = QW - 1 - k;
    div_t din, dout;

    if (k == 0) begin : g_first
      assign din = prep_q;
    end else begin : g_next
      assign din = dv_q[k-1];
    end

    always_comb begin
      dout = din;
      // Flag quotients too large for the kept bits
      if (k == 0) begin
        dout.ovf_x = (din.rem_x >> QW) >= NW'(din.den);
        dout.ovf_y = (din.rem_y >> QW) >= NW'(din.den);
      end
      if ((din.rem_x >> Sh) >= NW'(din.den)) begin
        dout.rem_x   = din.rem_x - (NW'(din.den) << Sh);
        dout.q_x[Sh] = 1'b1;
      end
      if ((din.rem_y >> Sh) >= NW'(din.den)) begin
        dout.rem_y   = din.rem_y - (NW'(din.den) << Sh);
        dout.q_y[Sh] = 1'b1;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        dv_q[k] <= dout;
      end
    end
  end

  // Apply sign, add screen center, saturate
  function automatic logic signed [COORD_WIDTH-1:0] finish(
    input logic [QW-1:0]          q,
    input logic                   neg,
    input logic                   ovf,
    input logic signed [SUMW-1:0] ctr
  );
    logic [QW-1:0]          qm;
    logic signed [SUMW-1:0] qs;
    logic signed [SUMW-1:0] sum;
    qm  = ovf ? '1 : q;
    qs  = neg ? -SUMW'(qm) : SUMW'(qm);
    sum = qs + ctr;
    if (sum > SatHi) begin
      sum = SatHi;
    end else if (sum < SatLo) begin
      sum = SatLo;
    end
    return sum[COORD_WIDTH-1:0];
  endfunction

  logic signed [COORD_WIDTH-1:0] sx_q, sy_q;
  logic                          ok_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      ok_q <= dv_q[QW-1].ok;
      if (dv_q[QW-1].ok) begin
        sx_q <= finish(dv_q[QW-1].q_x, dv_q[QW-1].neg_x, dv_q[QW-1].ovf_x, CtrX);
        sy_q <= finish(dv_q[QW-1].q_y, dv_q[QW-1].neg_y, dv_q[QW-1].ovf_y, CtrY);
      end else begin
        sx_q <= '0;
        sy_q <= '0;
      end
    end
  end

  assign sx_o = sx_q;
  assign sy_o = sy_q;
  assign ok_o = ok_q;

endmodule

// ----- design/triangle_shade_cull_project_top.sv -----
// Top level of the triangle shade, cull and projection block: config
// registers, face normal and shading pipeline, output skid. Depends on
// tscp_pkg and tscp_vertex.
//
// Usage:
//   s_axis carries one triangle per transfer: nine Q4.12 coordinates.
//   m_axis carries one result per triangle: six saturated Q12.4 screen
//   coordinates and the red, green and blue bytes in tdata, visible in tuser.
//   The cfg channel writes the six Q1.14 rotation sine and cosine registers;
//   it is always ready. The user must write it only while no triangle is in
//   flight; the block itself does not enforce this. One triangle is taken
//   every cycle while s_axis_tready is high; the depth is set by the
//   projection dividers, which resolve one quotient bit per stage,
//   COORD_WIDTH + 2 stages.
//   Reset clears the valid bits and skid, and loads the trig registers with
//   no rotation (cosines 1.0, sines 0).
//   When the receiver stalls, the held result stays on m_axis, one more result
//   is caught in the skid register, and s_axis_tready then drops; the whole
//   pipeline holds until the skid drains.
module triangle_shade_cull_project_top #(
  parameter int unsigned COORD_WIDTH = 16
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  // Fields from bit 0: vertex_a_x, vertex_a_y, vertex_a_z, vertex_b_x,
  // vertex_b_y, vertex_b_z, vertex_c_x, vertex_c_y, vertex_c_z
  input  logic [143:0]         s_axis_tdata,
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  // Fields from bit 0: screen_a_x, screen_a_y, screen_b_x, screen_b_y,
  // screen_c_x, screen_c_y, red, green, blue, zero fill
  output logic [((6*COORD_WIDTH+24+7)/8)*8-1:0] m_axis_tdata,
  // Fields from bit 0: visible
  output logic                 m_axis_tuser,
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [2:0]           cfg_index_i,
  input  logic [15:0]          cfg_data_i
);
  import tscp_pkg::*;

  localparam int unsigned TDW  = ((6 * COORD_WIDTH + 24 + 7) / 8) * 8;
  localparam int unsigned VLat = COORD_WIDTH + 7;
  localparam int unsigned NLat = 15;
  localparam int unsigned DLen = VLat - NLat;
  localparam int unsigned SW   = 58;
  localparam int unsigned PW   = 40;
  localparam int unsigned CW   = COORD_WIDTH;

  typedef struct packed {
    logic [SW-1:0] r;
    logic [SW-1:0] s;
    logic [SW-1:0] t;
    logic [7:0]    k;
  } chan_t;

  typedef struct packed {
    chan_t [2:0]   ch;
    logic [PW-1:0] p;
    logic          facing;
  } srch_t;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic       facing;
  } shade_t;

  // Configuration registers
  trig_t trig_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      trig_q <= '{cos_x: TRIG_ONE, sin_x: '0, cos_y: TRIG_ONE,
                  sin_y: '0, cos_z: TRIG_ONE, sin_z: '0};
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CfgCosX: trig_q.cos_x <= cfg_data_i;
        CfgSinX: trig_q.sin_x <= cfg_data_i;
        CfgCosY: trig_q.cos_y <= cfg_data_i;
        CfgSinY: trig_q.sin_y <= cfg_data_i;
        CfgCosZ: trig_q.cos_z <= cfg_data_i;
        CfgSinZ: trig_q.sin_z <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Pipeline enable and valid bits
  logic            en;
  logic [VLat-1:0] v_q;
  logic            skid_v_q;

  assign en            = !skid_v_q;
  assign s_axis_tready = en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en) begin
      v_q <= {v_q[VLat-2:0], s_axis_tvalid};
    end
  end

  logic signed [VW-1:0] vin [9];

  for (genvar i = 0; i < 9; i++) begin : g_in
    assign vin[i] = s_axis_tdata[VW*i +: VW];
  end

  // Vertex rotation and projection
  logic signed [CW-1:0] sx [3];
  logic signed [CW-1:0] sy [3];
  logic [2:0]           vok;

  for (genvar i = 0; i < 3; i++) begin : g_vtx
    tscp_vertex #(
      .COORD_WIDTH(COORD_WIDTH)
    ) u_vertex (
      .clk_i  (clk_i),
      .en_i   (en),
      .trig_i (trig_q),
      .x_i    (vin[3*i]),
      .y_i    (vin[3*i+1]),
      .z_i    (vin[3*i+2]),
      .sx_o   (sx[i]),
      .sy_o   (sy[i]),
      .ok_o   (vok[i])
    );
  end

  // Cross product of the edges
  logic signed [16:0] e1x, e1y, e1z, e2x, e2y, e2z;
  logic signed [33:0] c0, c1, c2, c3, c4, c5;
  logic signed [34:0] n1x_q, n1y_q, n1z_q;

  assign e1x = 17'(vin[3]) - 17'(vin[0]);
  assign e1y = 17'(vin[4]) - 17'(vin[1]);
  assign e1z = 17'(vin[5]) - 17'(vin[2]);
  assign e2x = 17'(vin[6]) - 17'(vin[0]);
  assign e2y = 17'(vin[7]) - 17'(vin[1]);
  assign e2z = 17'(vin[8]) - 17'(vin[2]);
  assign c0  = e1y * e2z;
  assign c1  = e1z * e2y;
  assign c2  = e1z * e2x;
  assign c3  = e1x * e2z;
  assign c4  = e1x * e2y;
  assign c5  = e1y * e2x;

  always_ff @(posedge clk_i) begin
    if (en) begin
      n1x_q <= 35'(c0) - 35'(c1);
      n1y_q <= 35'(c2) - 35'(c3);
      n1z_q <= 35'(c4) - 35'(c5);
    end
  end

  // Magnitudes and signs
  logic [33:0] a2_q [3];
  logic [2:0]  sg2_q;
  logic        nz2_q;
  logic [34:0] nneg_x, nneg_y, nneg_z;

  assign nneg_x = -n1x_q;
  assign nneg_y = -n1y_q;
  assign nneg_z = -n1z_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      a2_q[0] <= n1x_q[34] ? nneg_x[33:0] : n1x_q[33:0];
      a2_q[1] <= n1y_q[34] ? nneg_y[33:0] : n1y_q[33:0];
      a2_q[2] <= n1z_q[34] ? nneg_z[33:0] : n1z_q[33:0];
      sg2_q   <= {n1z_q[34], n1y_q[34], n1x_q[34]};
      nz2_q   <= (n1x_q != '0) || (n1y_q != '0) || (n1z_q != '0);
    end
  end

  // Shift that brings the largest magnitude below 2^15
  logic [33:0] orm;
  logic [4:0]  sh;
  logic [33:0] a3_q [3];
  logic [2:0]  sg3_q;
  logic        nz3_q;
  logic [4:0]  sh3_q;

  assign orm = a2_q[0] | a2_q[1] | a2_q[2];

  always_comb begin
    sh = '0;
    for (int i = 15; i < 34; i++) begin
      if (orm[i]) begin
        sh = 5'(i - 14);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      a3_q  <= a2_q;
      sg3_q <= sg2_q;
      nz3_q <= nz2_q;
      sh3_q <= sh;
    end
  end

  // Shrink the normal to 16-bit components
  logic signed [15:0] cn_q [3];
  logic               nz4_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        cn_q[i] <= sg3_q[i] ? -{1'b0, 15'(a3_q[i] >> sh3_q)}
                            : {1'b0, 15'(a3_q[i] >> sh3_q)};
      end
      nz4_q <= nz3_q;
    end
  end

  // Squares and light dot product
  logic signed [31:0] sqx, sqy, sqz;
  logic [30:0]        sq5_q [3];
  logic signed [20:0] d5_q;
  logic               nzp5_q, nz5_q;

  assign sqx = cn_q[0] * cn_q[0];
  assign sqy = cn_q[1] * cn_q[1];
  assign sqz = cn_q[2] * cn_q[2];

  always_ff @(posedge clk_i) begin
    if (en) begin
      sq5_q[0] <= sqx[30:0];
      sq5_q[1] <= sqy[30:0];
      sq5_q[2] <= sqz[30:0];
      d5_q     <= 21'(cn_q[0]) * 21'sd5 + 21'(cn_q[1]) * 21'sd7
                + 21'(cn_q[2]) * 21'sd10;
      nzp5_q   <= !cn_q[2][15] && (cn_q[2] != '0);
      nz5_q    <= nz4_q;
    end
  end

  // Squared norm, facing test, squared dot product
  logic [31:0]        n2;
  logic signed [41:0] dsq;
  logic [31:0]        n2_6_q;
  logic [39:0]        d2_6_q;
  logic               dpos6_q, face6_q, nz6_q;

  assign n2  = 32'(sq5_q[0]) + 32'(sq5_q[1]) + 32'(sq5_q[2]);
  assign dsq = d5_q * d5_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      n2_6_q  <= n2;
      d2_6_q  <= dsq[39:0];
      dpos6_q <= !d5_q[20] && (d5_q != '0);
      face6_q <= nzp5_q && ((37'(sq5_q[2]) * 37'd100) > 37'(n2));
      nz6_q   <= nz5_q;
    end
  end

  // Search bounds: k*k*174*n2 <= c*c*d*d
  srch_t srch_d, sr_q [9];

  always_comb begin
    srch_d        = '0;
    srch_d.p      = nz6_q ? (PW'(n2_6_q) * PW'(LIGHT_N2)) : PW'(1);
    srch_d.facing = face6_q;
    for (int c = 0; c < 3; c++) begin
      srch_d.ch[c].r = dpos6_q ? (SW'(d2_6_q) * SW'(CHAN_SQ[c])) : '0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      sr_q[0] <= srch_d;
    end
  end

  // Bit-serial search of the shade level, S = k*k*P and T = k*P carried along
  for (genvar g = 0; g < 8; g++) begin : g_srch
    localparam int unsigned Bit = 7 - g;
    srch_t sin_s, sout_s;
    logic [SW-1:0] cand [3];

    assign sin_s = sr_q[g];

    always_comb begin
      sout_s = sin_s;
      for (int c = 0; c < 3; c++) begin
        cand[c] = sin_s.ch[c].s + (sin_s.ch[c].t << (Bit + 1))
                + (SW'(sin_s.p) << (2 * Bit));
        if (cand[c] <= sin_s.ch[c].r) begin
          sout_s.ch[c].s      = cand[c];
          sout_s.ch[c].t      = sin_s.ch[c].t + (SW'(sin_s.p) << Bit);
          sout_s.ch[c].k[Bit] = 1'b1;
        end
      end
    end

    always_ff @(posedge clk_i) begin
      if (en) begin
        sr_q[g+1] <= sout_s;
      end
    end
  end

  // Colors, then delay to line up with the vertex results
  shade_t shade_d;
  shade_t dly_q [DLen];

  assign shade_d.red    = CHAN_BASE[0] + sr_q[8].ch[0].k;
  assign shade_d.green  = CHAN_BASE[1] + sr_q[8].ch[1].k;
  assign shade_d.blue   = CHAN_BASE[2] + sr_q[8].ch[2].k;
  assign shade_d.facing = sr_q[8].facing;

  always_ff @(posedge clk_i) begin
    if (en) begin
      dly_q[0] <= shade_d;
      for (int i = 1; i < DLen; i++) begin
        dly_q[i] <= dly_q[i-1];
      end
    end
  end

  // Pack the result
  logic [TDW-1:0] res_data;
  logic           res_user;

  always_comb begin
    res_data = '0;
    for (int i = 0; i < 3; i++) begin
      res_data[2*CW*i +: CW]      = sx[i];
      res_data[2*CW*i + CW +: CW] = sy[i];
    end
    res_data[6*CW +: 8]      = dly_q[DLen-1].red;
    res_data[6*CW + 8 +: 8]  = dly_q[DLen-1].green;
    res_data[6*CW + 16 +: 8] = dly_q[DLen-1].blue;
    res_user = dly_q[DLen-1].facing && (&vok);
  end

  // Output register and skid
  logic [TDW-1:0] out_data_q, skid_data_q;
  logic           out_user_q, skid_user_q;
  logic           out_v_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q  <= 1'b0;
      skid_v_q <= 1'b0;
    end else if (!out_v_q || m_axis_tready) begin
      if (skid_v_q) begin
        out_v_q  <= 1'b1;
        skid_v_q <= 1'b0;
      end else begin
        out_v_q <= v_q[VLat-1];
      end
    end else if (v_q[VLat-1] && en) begin
      skid_v_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!out_v_q || m_axis_tready) begin
      if (skid_v_q) begin
        out_data_q <= skid_data_q;
        out_user_q <= skid_user_q;
      end else begin
        out_data_q <= res_data;
        out_user_q <= res_user;
      end
    end else if (v_q[VLat-1] && en) begin
      skid_data_q <= res_data;
      skid_user_q <= res_user;
    end
  end

  assign m_axis_tvalid = out_v_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tuser  = out_user_q;

  // A held skid entry always has a result in front of it
  assert property (@(posedge clk_i) disable iff (!rst_ni) skid_v_q |-> out_v_q)
    else $error("skid holds a result while the output is empty");

  // The skid stays full while the receiver stalls
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (skid_v_q && !m_axis_tready) |=> skid_v_q)
    else $error("skid entry lost during stall");

  // The skid fills only behind a stalled output
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(skid_v_q) |-> $past(m_axis_tvalid && !m_axis_tready))
    else $error("skid filled without a stall");

  // Colors never fall below their base
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tdata[6*CW +: 8] >= 8'd50)
                   && (m_axis_tdata[6*CW + 8 +: 8] >= 8'd100)
                   && (m_axis_tdata[6*CW + 16 +: 8] >= 8'd200))
    else $error("color below base level");

endmodule

// ----- sim/tscp_checker.sv -----
// Checker for the triangle shade, cull and projection block: watches the cfg,
// s_axis and m_axis channels, predicts each result and compares it in order.
// Depends on tscp_pkg for the register index names.
module tscp_checker
  import tscp_pkg::*;
(
  input  logic         clk_i,
  input  logic [143:0] s_axis_tdata,
  input  logic         s_axis_tvalid,
  input  logic         s_axis_tready,
  input  logic [119:0] m_axis_tdata,
  input  logic         m_axis_tuser,
  input  logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  input  logic         cfg_valid_i,
  input  logic         cfg_ready_o,
  input  logic [2:0]   cfg_index_i,
  input  logic [15:0]  cfg_data_i,
  output int           fail_count_o,
  output int           pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [5:0][15:0] screen;
    logic [7:0]       red;
    logic [7:0]       green;
    logic [7:0]       blue;
    logic             visible;
  } shade_result_t;

  shade_result_t result_q[$];
  longint        trig[6];
  int            fails;

  assign fail_count_o = fails;
  assign pending_o    = result_q.size();

  function automatic longint floor_div(longint n, longint d);
    longint q;
    q = n / d;
    if ((n % d) != 0 && n < 0) q--;
    return q;
  endfunction

  function automatic longint round_q12(longint v);
    return floor_div(v + RND_BIAS, 16384);
  endfunction

  function automatic logic [15:0] clamp_coord(longint v);
    if (v > 32767) v = 32767;
    if (v < -32768) v = -32768;
    return v[15:0];
  endfunction

  // Rotate about X, Y, Z and project; return 0 on non-positive depth
  function automatic bit place_vertex(longint x, longint y, longint z,
                                      output logic [15:0] sx,
                                      output logic [15:0] sy);
    longint y1, z1, x2, z2, x3, y3, w;
    y1 = round_q12(y * trig[CfgCosX] - z * trig[CfgSinX]);
    z1 = round_q12(y * trig[CfgSinX] + z * trig[CfgCosX]);
    x2 = round_q12(x * trig[CfgCosY] + z1 * trig[CfgSinY]);
    z2 = round_q12(z1 * trig[CfgCosY] - x * trig[CfgSinY]);
    x3 = round_q12(x2 * trig[CfgCosZ] - y1 * trig[CfgSinZ]);
    y3 = round_q12(x2 * trig[CfgSinZ] + y1 * trig[CfgCosZ]);
    w  = W_BIAS + z2;
    if (w <= 0) begin
      sx = '0;
      sy = '0;
      return 0;
    end
    sx = clamp_coord(CENTER_X + floor_div(PROJ_K * x3 + w, 2 * w));
    sy = clamp_coord(CENTER_Y + floor_div(PROJ_K * y3 + w, 2 * w));
    return 1;
  endfunction

  // Largest k in [0,c] with k*k*174*n2 <= c*c*d*d
  function automatic longint channel_level(longint unsigned c, longint unsigned d,
                                           longint unsigned n2);
    longint unsigned rhs, lo, hi, mid;
    rhs = c * c * d * d;
    lo  = 0;
    hi  = c;
    while (lo < hi) begin
      mid = (lo + hi + 1) >> 1;
      if (mid * mid * LIGHT_N2 * n2 <= rhs) lo = mid;
      else hi = mid - 1;
    end
    return lo;
  endfunction

  function automatic longint shift_mag(longint v, int s);
    longint m;
    m = (v < 0) ? -v : v;
    m = m >>> s;
    return (v < 0) ? -m : m;
  endfunction

  function automatic shade_result_t shade_triangle(logic [143:0] tri_data);
    shade_result_t r;
    longint v[9];
    longint nx, ny, nz, mx, d, n2;
    bit drawable, facing;
    int s;
    for (int i = 0; i < 9; i++) v[i] = longint'($signed(tri_data[16*i +: 16]));
    drawable = 1;
    for (int k = 0; k < 3; k++)
      drawable &= place_vertex(v[3*k], v[3*k+1], v[3*k+2],
                               r.screen[2*k], r.screen[2*k+1]);
    nx = (v[4]-v[1]) * (v[8]-v[2]) - (v[5]-v[2]) * (v[7]-v[1]);
    ny = (v[5]-v[2]) * (v[6]-v[0]) - (v[3]-v[0]) * (v[8]-v[2]);
    nz = (v[3]-v[0]) * (v[7]-v[1]) - (v[4]-v[1]) * (v[6]-v[0]);
    r.red   = 50;
    r.green = 100;
    r.blue  = 200;
    facing  = 0;
    if (nx != 0 || ny != 0 || nz != 0) begin
      // Scale the normal down until every component fits 16 bits signed
      mx = (nx < 0) ? -nx : nx;
      if (((ny < 0) ? -ny : ny) > mx) mx = (ny < 0) ? -ny : ny;
      if (((nz < 0) ? -nz : nz) > mx) mx = (nz < 0) ? -nz : nz;
      s = 0;
      while ((mx >>> s) >= 32768) s++;
      nx = shift_mag(nx, s);
      ny = shift_mag(ny, s);
      nz = shift_mag(nz, s);
      n2 = nx * nx + ny * ny + nz * nz;
      d  = 5 * nx + 7 * ny + 10 * nz;
      if (d > 0) begin
        r.red   = 50 + channel_level(200, d, n2);
        r.green = 100 + channel_level(150, d, n2);
        r.blue  = 200 + channel_level(55, d, n2);
      end
      facing = nz > 0 && 100 * nz * nz > n2;
    end
    r.visible = drawable && facing;
    return r;
  endfunction

  initial begin
    fails = 0;
    trig[CfgCosX] = 16384; trig[CfgSinX] = 0;
    trig[CfgCosY] = 16384; trig[CfgSinY] = 0;
    trig[CfgCosZ] = 16384; trig[CfgSinZ] = 0;
  end

  // Track register writes, queue predictions, compare results in order
  always @(posedge clk_i) begin
    shade_result_t want, got;
    if (cfg_valid_i && cfg_ready_o && cfg_index_i <= CfgSinZ)
      trig[cfg_index_i] = longint'($signed(cfg_data_i));
    if (s_axis_tvalid && s_axis_tready)
      result_q.push_back(shade_triangle(s_axis_tdata));
    if (m_axis_tvalid && m_axis_tready) begin
      got.screen  = m_axis_tdata[95:0];
      got.red     = m_axis_tdata[103:96];
      got.green   = m_axis_tdata[111:104];
      got.blue    = m_axis_tdata[119:112];
      got.visible = m_axis_tuser;
      if (result_q.size() == 0) begin
        $display("%0t: result with nothing expected: %h", $time, got);
        fails++;
      end else begin
        want = result_q.pop_front();
        for (int i = 0; i < 6; i++)
          if (got.screen[i] !== want.screen[i]) begin
            $display("%0t: screen coord %0d expected %0d actual %0d", $time, i,
                     $signed(want.screen[i]), $signed(got.screen[i]));
            fails++;
          end
        if (got.red !== want.red) begin
          $display("%0t: red expected %0d actual %0d", $time, want.red, got.red);
          fails++;
        end
        if (got.green !== want.green) begin
          $display("%0t: green expected %0d actual %0d", $time, want.green, got.green);
          fails++;
        end
        if (got.blue !== want.blue) begin
          $display("%0t: blue expected %0d actual %0d", $time, want.blue, got.blue);
          fails++;
        end
        if (got.visible !== want.visible) begin
          $display("%0t: visible expected %0d actual %0d", $time, want.visible,
                   got.visible);
          fails++;
        end
      end
    end
  end

endmodule

// ----- sim/testbench.sv -----
// Top of the triangle shade, cull and projection testbench: clock, reset,
// register phases, triangle stimulus and verdict. Depends on tscp_pkg,
// triangle_shade_cull_project_top and tscp_checker.
module testbench;
  import tscp_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int DRAIN_CYCLES = 40;
  localparam int STALL_LIMIT  = 3000;

  logic         clk_i, rst_ni;
  logic [143:0] s_axis_tdata;
  logic         s_axis_tvalid, s_axis_tready;
  logic [119:0] m_axis_tdata;
  logic         m_axis_tuser, m_axis_tvalid, m_axis_tready;
  logic         cfg_valid_i, cfg_ready_o;
  logic [2:0]   cfg_index_i;
  logic [15:0]  cfg_data_i;
  int           fail_count, pending, idle_cycles, burst_left;

  triangle_shade_cull_project_top u_dut (.*);

  tscp_checker u_checker (
    .clk_i, .s_axis_tdata, .s_axis_tvalid, .s_axis_tready, .m_axis_tdata,
    .m_axis_tuser, .m_axis_tvalid, .m_axis_tready, .cfg_valid_i, .cfg_ready_o,
    .cfg_index_i, .cfg_data_i, .fail_count_o(fail_count), .pending_o(pending)
  );

  initial begin
    clk_i = 0;
    forever #5 clk_i = ~clk_i;
  end

  // Receiver stalls: the pattern steps through four modes over simulation time
  always @(posedge clk_i or negedge rst_ni) begin
    logic [31:0] cyc;
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else begin
      cyc = $urandom;
      case ((idle_cycles + $time / 640) % 4)
        0: m_axis_tready <= 1'b1;
        1: m_axis_tready <= cyc[0];
        2: m_axis_tready <= (cyc[3:0] == 4'd0);
        default: m_axis_tready <= (cyc[1:0] != 2'd0);
      endcase
    end
  end

  // Watchdog on cycles with no transfer on any channel
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (cfg_valid_i && cfg_ready_o)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("testbench NOT OK");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic write_reg(input logic [2:0] idx, input logic [15:0] value);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
  endtask

  // Write all six trig registers back to back, then one ignored index
  task automatic load_trig(input logic [15:0] cx, sx, cy, sy, cz, sz);
    write_reg(CfgCosX, cx);
    write_reg(CfgSinX, sx);
    write_reg(CfgCosY, cy);
    write_reg(CfgSinY, sy);
    write_reg(CfgCosZ, cz);
    write_reg(CfgSinZ, sz);
    write_reg(3'($urandom_range(6, 7)), 16'($urandom));
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  // Send one triangle; open a random gap when the burst runs out
  task automatic send_tri(input logic [143:0] tri_data);
    int gap;
    s_axis_tdata  <= tri_data;
    s_axis_tvalid <= 1'b1;
    do @(posedge clk_i); while (!s_axis_tready);
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        s_axis_tvalid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end else begin
      burst_left--;
    end
  endtask

  function automatic logic [143:0] pack_tri(input int c[9]);
    logic [143:0] t;
    for (int i = 0; i < 9; i++) t[16*i +: 16] = 16'(c[i]);
    return t;
  endfunction

  function automatic int edge_value();
    case ($urandom_range(0, 5))
      0: return -32768;
      1: return 32767;
      2: return 0;
      3: return 1;
      4: return -1;
      default: return $urandom_range(0, 65535) - 32768;
    endcase
  endfunction

  // Mostly compact triangles near the origin, some full range and extremes
  function automatic logic [143:0] random_tri();
    int c[9];
    int cx, cy, cz, spread;
    case ($urandom_range(0, 9))
      0, 1: for (int i = 0; i < 9; i++) c[i] = $urandom_range(0, 65535) - 32768;
      2: for (int i = 0; i < 9; i++) c[i] = edge_value();
      default: begin
        spread = 1 << $urandom_range(4, 13);
        cx = $urandom_range(0, 16384) - 8192;
        cy = $urandom_range(0, 16384) - 8192;
        cz = $urandom_range(0, 40000) - 24000;
        for (int k = 0; k < 3; k++) begin
          c[3*k]   = cx + $urandom_range(0, 2*spread) - spread;
          c[3*k+1] = cy + $urandom_range(0, 2*spread) - spread;
          c[3*k+2] = cz + $urandom_range(0, 2*spread) - spread;
        end
      end
    endcase
    return pack_tri(c);
  endfunction

  task automatic wait_idle();
    while (pending != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  initial begin
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    cfg_valid_i   = 1'b0;
    cfg_index_i   = '0;
    cfg_data_i    = '0;
    idle_cycles   = 0;
    burst_left    = 0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: degenerate, extremes, facing both ways, bad depth, saturation
    send_tri(pack_tri('{0, 0, 0, 0, 0, 0, 0, 0, 0}));
    send_tri(pack_tri('{4096, 4096, 0, 4096, 4096, 0, 4096, 4096, 0}));
    send_tri(pack_tri('{0, 0, 0, 4096, 0, 0, 0, 4096, 0}));
    send_tri(pack_tri('{0, 0, 0, 0, 4096, 0, 4096, 0, 0}));
    send_tri(pack_tri('{0, 0, 0, 4096, 0, 2048, 0, 4096, 2048}));
    send_tri(pack_tri('{0, 0, -32768, 4096, 0, 0, 0, 4096, 0}));
    send_tri(pack_tri('{0, 0, -20480, 4096, 0, 0, 0, 4096, 0}));
    send_tri(pack_tri('{32767, 32767, -20479, -32768, 32767, -20470,
                        32767, -32768, -20400}));
    send_tri(pack_tri('{-32768, -32768, -32768, 32767, -32768, 32767,
                        -32768, 32767, 32767}));
    send_tri(pack_tri('{32767, 32767, 32767, 32767, 32767, 32767,
                        32767, 32767, 32767}));
    send_tri(pack_tri('{-32768, 32767, -32768, 32767, -32768, 32767,
                        32767, 32767, -32768}));
    send_tri(pack_tri('{0, 0, 0, 1, 0, 0, 0, 1, 0}));
    send_tri(pack_tri('{0, 0, 0, 1, 0, 0, 2, 0, 0}));
    send_tri(pack_tri('{0, 0, 0, 4096, 0, 40, 0, 4096, 40}));
    s_axis_tvalid <= 1'b0;
    wait_idle();

    // Register phases: identity, extremes, out-of-range, random angles
    for (int phase = 0; phase < 7; phase++) begin
      case (phase)
        0: load_trig(16384, 0, 16384, 0, 16384, 0);
        1: load_trig(-16384, 16384, -16384, -16384, 16384, -16384);
        2: load_trig(16'h8000, 16'h7fff, 16'h7fff, 16'h8000, 16'h8000, 16'h7fff);
        3: load_trig(0, 16384, 0, -16384, 0, 16384);
        4: load_trig(11585, 11585, 14189, -8192, 15137, 6270);
        default: load_trig($urandom_range(0, 32768) - 16384,
                           $urandom_range(0, 32768) - 16384,
                           $urandom_range(0, 32768) - 16384,
                           $urandom_range(0, 32768) - 16384,
                           16'($urandom), 16'($urandom));
      endcase
      repeat (160) send_tri(random_tri());
      s_axis_tvalid <= 1'b0;
      wait_idle();
    end

    if (fail_count == 0) begin
      $display("testbench OK");
    end else begin
      $display("testbench NOT OK");
    end
    $finish;
  end

endmodule
